FILE: rtl/nal_unit_extractor_core_assert.svh
// ----------------------------------------------------------------------------
// NAL unit extractor assertion macros
// Concurrent assertion wrappers that compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef NAL_UNIT_EXTRACTOR_CORE_ASSERT_SVH
`define NAL_UNIT_EXTRACTOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define NUE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define NUE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define NUE_ASSERT(lbl, clk, rst_n, prop, msg)
`define NUE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/nue_pkg.sv
// ----------------------------------------------------------------------------
// NAL unit extractor package
// Shared constants and types for the extractor front end, queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

package nue_pkg;

    localparam int BYTE_W     = 8;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [BYTE_W-1:0] ZERO_BYTE  = 8'h00;
    localparam logic [BYTE_W-1:0] START_BYTE = 8'h01;
    localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'h03;

    // Work for one input byte: held zeros, then an optional data byte,
    // then an optional end marker.
    typedef struct packed {
        logic [1:0]        zero_cnt;
        logic              first;
        logic              byte_en;
        logic [BYTE_W-1:0] data;
        logic              end_en;
    } t_desc;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

FILE: rtl/nue_in_if.sv
// ----------------------------------------------------------------------------
// NAL unit extractor input channel
// Valid/ready channel carrying one raw stream byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface nue_in_if import nue_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              buffer_last;

    modport source (output valid, output in_byte, output buffer_last, input ready);
    modport sink   (input valid, input in_byte, input buffer_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/nue_out_if.sv
// ----------------------------------------------------------------------------
// NAL unit extractor output channel
// Valid/ready channel carrying one NAL byte or end marker per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface nue_out_if import nue_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              nal_first;
    logic              nal_end;
    logic              run_last;

    modport source (output valid, output out_byte, output byte_valid, output nal_first,
                    output nal_end, output run_last, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input nal_first,
                    input nal_end, input run_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/nue_front.sv
// ----------------------------------------------------------------------------
// NAL unit extractor front end
// Tracks start codes, held zeros and escapes, and queues the work per byte.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nal_unit_extractor_core_assert.svh"

module nue_front import nue_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    nue_in_if.sink   i_in_ch,
    input  t_q_stat  i_q_stat,
    output logic     o_push,
    output t_desc    o_desc
);

    logic       r_in_unit, n_in_unit;
    logic [1:0] r_search,  n_search;
    logic [1:0] r_held,    n_held;
    logic [1:0] r_esc,     n_esc;
    logic       r_nonempty, n_nonempty;

    logic       accept;
    logic       is_zero;
    logic       is_start;
    logic       is_esc;
    logic [2:0] esc_sum;
    t_desc      desc;

    assign i_in_ch.ready = !i_q_stat.full;
    assign accept   = i_in_ch.valid && i_in_ch.ready;
    assign is_zero  = (i_in_ch.in_byte == ZERO_BYTE);
    assign is_start = (i_in_ch.in_byte == START_BYTE);
    assign is_esc   = (i_in_ch.in_byte == ESC_BYTE);
    assign esc_sum  = {1'b0, r_esc} + {1'b0, r_held};

    always_comb begin
        n_in_unit    = r_in_unit;
        n_search     = r_search;
        n_held       = r_held;
        n_esc        = r_esc;
        n_nonempty   = r_nonempty;
        desc         = '0;
        desc.data    = i_in_ch.in_byte;
        desc.first   = !r_nonempty;

        if (r_in_unit) begin
            if ((r_held == 2'd2) && (is_zero || is_start)) begin
                desc.end_en = r_nonempty;
                n_held      = 2'd0;
                n_esc       = 2'd0;
                n_nonempty  = 1'b0;
                if (is_start) begin
                    n_in_unit = 1'b1;
                    n_search  = 2'd0;
                end else begin
                    n_in_unit = 1'b0;
                    n_search  = 2'd2;
                end
            end else if (is_zero) begin
                n_held = r_held + 2'd1;
            end else begin
                desc.zero_cnt = r_held;
                n_held        = 2'd0;
                n_esc         = 2'd0;
                if (is_esc && (esc_sum >= 3'd2)) begin
                    n_nonempty = r_nonempty || (r_held != 2'd0);
                end else begin
                    desc.byte_en = 1'b1;
                    n_nonempty   = 1'b1;
                end
            end
        end else begin
            if (is_zero) begin
                if (r_search != 2'd2) begin
                    n_search = r_search + 2'd1;
                end
            end else if (is_start && (r_search == 2'd2)) begin
                n_in_unit  = 1'b1;
                n_search   = 2'd0;
                n_held     = 2'd0;
                n_esc      = 2'd0;
                n_nonempty = 1'b0;
            end else begin
                n_search = 2'd0;
            end
        end

        if (i_in_ch.buffer_last) begin
            if (n_in_unit) begin
                if (n_held != 2'd0) begin
                    desc.zero_cnt = n_held;
                end
                desc.end_en = desc.end_en || n_nonempty || (n_held != 2'd0);
            end
            n_in_unit  = 1'b0;
            n_search   = 2'd0;
            n_held     = 2'd0;
            n_esc      = 2'd0;
            n_nonempty = 1'b0;
        end
    end

    assign o_desc = desc;
    assign o_push = accept && ((desc.zero_cnt != 2'd0) || desc.byte_en || desc.end_en);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_unit  <= 1'b0;
            r_search   <= 2'd0;
            r_held     <= 2'd0;
            r_esc      <= 2'd0;
            r_nonempty <= 1'b0;
        end else if (accept) begin
            r_in_unit  <= n_in_unit;
            r_search   <= n_search;
            r_held     <= n_held;
            r_esc      <= n_esc;
            r_nonempty <= n_nonempty;
        end
    end

    // Held zeros never exceed two, and the unit counters are clear while searching.
    `NUE_ASSERT(a_held_bound, i_clk, i_rst_n, r_held != 2'd3, "held zero count out of range")
    `NUE_ASSERT_IMP(a_search_clean, i_clk, i_rst_n, !r_in_unit,
        (r_held == 2'd0) && (r_esc == 2'd0) && !r_nonempty, "unit state left while searching")

endmodule

`default_nettype wire

FILE: rtl/nue_fifo.sv
// ----------------------------------------------------------------------------
// NAL unit extractor work queue
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nal_unit_extractor_core_assert.svh"

module nue_fifo import nue_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_desc    i_desc,
    input  logic     i_pop,
    output t_desc    o_head,
    output t_q_stat  o_stat
);

    t_desc                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wp;
    logic [FIFO_AW-1:0]   r_rp;
    logic [FIFO_AW:0]     r_cnt;

    assign o_stat.full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + FIFO_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (FIFO_AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (FIFO_AW+1)'(1);
            end
        end
    end

    `NUE_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && o_stat.full), "push into full queue")
    `NUE_ASSERT(a_no_underflow, i_clk, i_rst_n, !(i_pop && o_stat.empty),
        "pop from empty queue")

endmodule

`default_nettype wire

FILE: rtl/nue_back.sv
// ----------------------------------------------------------------------------
// NAL unit extractor back end
// Expands queued work into output beats through a register, one per cycle unless the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nal_unit_extractor_core_assert.svh"

module nue_back import nue_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_desc     i_head,
    input  t_q_stat   i_q_stat,
    output logic      o_pop,
    nue_out_if.source o_out_ch
);

    logic [1:0]        r_idx;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_byte_valid;
    logic              r_nal_first;
    logic              r_nal_end;
    logic              r_run_last;

    logic              load;
    logic              emit;
    logic [2:0]        total;
    logic              zero_slot;
    logic              byte_slot;
    logic              is_data;
    logic              is_last;

    assign load      = !r_out_valid || o_out_ch.ready;
    assign emit      = load && !i_q_stat.empty;
    assign total     = {1'b0, i_head.zero_cnt} + {2'b00, i_head.byte_en}
                     + {2'b00, i_head.end_en};
    assign zero_slot = (r_idx < i_head.zero_cnt);
    assign byte_slot = (r_idx == i_head.zero_cnt) && i_head.byte_en;
    assign is_data   = zero_slot || byte_slot;
    assign is_last   = (({1'b0, r_idx} + 3'd1) == total);
    assign o_pop     = emit && is_last;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte   <= byte_slot ? i_head.data : ZERO_BYTE;
            r_byte_valid <= is_data;
            r_nal_first  <= is_data && i_head.first && (r_idx == 2'd0);
            r_nal_end    <= !is_data;
            r_run_last   <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 2'd0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
                r_idx       <= is_last ? 2'd0 : r_idx + 2'd1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_ch.valid      = r_out_valid;
    assign o_out_ch.out_byte   = r_out_byte;
    assign o_out_ch.byte_valid = r_byte_valid;
    assign o_out_ch.nal_first  = r_nal_first;
    assign o_out_ch.nal_end    = r_nal_end;
    assign o_out_ch.run_last   = r_run_last;

    // A partly expanded entry must still sit at the head of the queue.
    `NUE_ASSERT_IMP(a_idx_has_head, i_clk, i_rst_n, r_idx != 2'd0, !i_q_stat.empty,
        "beat index advanced without queued work")

endmodule

`default_nettype wire

FILE: rtl/nal_unit_extractor_core.sv
// ----------------------------------------------------------------------------
// NAL unit extractor core
// Finds Annex B start codes, strips emulation prevention bytes and emits
// NAL bytes with header and end markers.
//
//   Port       Dir   Beat contents
//   i_in_ch    in    in_byte, buffer_last
//   o_out_ch   out   out_byte, byte_valid, nal_first, nal_end, run_last
//
// One input byte is accepted per cycle while the four-entry work queue has room.
// The back end sends one output beat per cycle unless the output stalls; a byte
// yields up to four beats. The first beat passes through a queue entry and then
// the output register. Reset is synchronous and clears the pointers, counters
// and state flags. A stalled output only stops input once the work queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module nal_unit_extractor_core import nue_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    nue_in_if.sink    i_in_ch,
    nue_out_if.source o_out_ch
);

    t_desc   push_desc;
    t_desc   head_desc;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    nue_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (i_in_ch),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_desc   (push_desc)
    );

    nue_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_head  (head_desc),
        .o_stat  (q_stat)
    );

    nue_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head_desc),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out_ch (o_out_ch)
    );

endmodule

`default_nettype wire

FILE: tb/nal_unit_extractor_core_checker.sv
// ----------------------------------------------------------------------------
// NAL unit extractor checker
// Watches both channels of the extractor. Every accepted input byte is run
// through a behavioral copy of the start code search, terminator detection
// and emulation prevention removal. The beats it predicts are queued and
// compared field by field, in order, with the beats the block sends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nal_unit_extractor_core_checker import nue_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    nue_in_if    i_in_ch,
    nue_out_if   i_out_ch,
    output int   o_mismatch_count,
    output int   o_pending
);

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              nal_first;
        logic              nal_end;
        logic              run_last;
    } t_nal_beat;

    t_nal_beat  expected_beats[$];
    t_nal_beat  step_beats[$];
    int         mismatch_count;

    logic       unit_open;
    logic [1:0] hunt_zeros;
    logic [1:0] held_zeros;
    logic [1:0] esc_zeros;
    logic       unit_has_data;

    function automatic t_nal_beat make_beat(input logic [BYTE_W-1:0] b, input logic is_data,
                                            input logic is_first, input logic is_end);
        return {b, is_data, is_first, is_end, 1'b0};
    endfunction

    function automatic void add_step_beat(input t_nal_beat beat);
        step_beats = {step_beats, beat};
    endfunction

    function automatic void clear_state();
        unit_open     = 1'b0;
        hunt_zeros    = 2'd0;
        held_zeros    = 2'd0;
        esc_zeros     = 2'd0;
        unit_has_data = 1'b0;
    endfunction

    function automatic void open_unit();
        clear_state();
        unit_open = 1'b1;
    endfunction

    function automatic void emit_data(input logic [BYTE_W-1:0] b);
        add_step_beat(make_beat(b, 1'b1, !unit_has_data, 1'b0));
        unit_has_data = 1'b1;
        if (b == ZERO_BYTE) begin
            if (esc_zeros < 2'd2) begin
                esc_zeros = esc_zeros + 2'd1;
            end
        end else begin
            esc_zeros = 2'd0;
        end
    endfunction

    function automatic void release_held();
        while (held_zeros > 2'd0) begin
            emit_data(ZERO_BYTE);
            held_zeros = held_zeros - 2'd1;
        end
    endfunction

    function automatic void extract_byte(input logic [BYTE_W-1:0] b, input logic last);
        step_beats.delete();
        if (unit_open) begin
            if (held_zeros == 2'd2 && (b == ZERO_BYTE || b == START_BYTE)) begin
                if (unit_has_data) begin
                    add_step_beat(make_beat(ZERO_BYTE, 1'b0, 1'b0, 1'b1));
                end
                clear_state();
                if (b == START_BYTE) begin
                    open_unit();
                end else begin
                    hunt_zeros = 2'd2;
                end
            end else if (b == ZERO_BYTE) begin
                held_zeros = held_zeros + 2'd1;
            end else begin
                release_held();
                if (b == ESC_BYTE && esc_zeros == 2'd2) begin
                    esc_zeros = 2'd0;
                end else begin
                    emit_data(b);
                end
            end
        end else begin
            if (b == ZERO_BYTE) begin
                if (hunt_zeros < 2'd2) begin
                    hunt_zeros = hunt_zeros + 2'd1;
                end
            end else if (b == START_BYTE && hunt_zeros == 2'd2) begin
                open_unit();
            end else begin
                hunt_zeros = 2'd0;
            end
        end
        if (last) begin
            if (unit_open) begin
                release_held();
                if (unit_has_data) begin
                    add_step_beat(make_beat(ZERO_BYTE, 1'b0, 1'b0, 1'b1));
                end
            end
            clear_state();
        end
        if (step_beats.size() > 0) begin
            step_beats[step_beats.size() - 1].run_last = 1'b1;
        end
        expected_beats = {expected_beats, step_beats};
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void check_beat();
        t_nal_beat got;
        t_nal_beat want;
        got = {i_out_ch.out_byte, i_out_ch.byte_valid, i_out_ch.nal_first,
               i_out_ch.nal_end, i_out_ch.run_last};
        if (expected_beats.size() == 0) begin
            $display("%0t: unexpected beat: expected none, %s %02h valid %b first %b %s %b %s %b",
                     $time, "actual byte", got.out_byte, got.byte_valid, got.nal_first,
                     "end", got.nal_end, "last", got.run_last);
            mismatch_count++;
        end else begin
            want = expected_beats.pop_front();
            check_field("out_byte", want.out_byte, got.out_byte);
            check_field("byte_valid", want.byte_valid, got.byte_valid);
            check_field("nal_first", want.nal_first, got.nal_first);
            check_field("nal_end", want.nal_end, got.nal_end);
            check_field("run_last", want.run_last, got.run_last);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
            expected_beats.delete();
        end else begin
            if (i_out_ch.valid && i_out_ch.ready) begin
                check_beat();
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                extract_byte(i_in_ch.in_byte, i_in_ch.buffer_last);
            end
        end
        o_pending        <= expected_beats.size();
        o_mismatch_count <= mismatch_count;
    end

endmodule

FILE: tb/nal_unit_extractor_core_tb.sv
// ----------------------------------------------------------------------------
// NAL unit extractor testbench
// Feeds the extractor a directed byte stream covering start codes, empty
// units, both terminators, escape bytes and buffer ends, then random Annex B
// buffers mixed with noise. The input side sends in bursts with gaps and the
// output side stalls in changing patterns. The checker grades every beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nal_unit_extractor_core_tb import nue_pkg::*;;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int RANDOM_ITEMS  = 270;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE
    } t_ready_mode;

    logic i_clk;
    logic i_rst_n;

    nue_in_if  in_ch ();
    nue_out_if out_ch ();

    int          mismatches;
    int          pending;
    int          cycle_count;
    int          items_sent;
    int          burst_left;
    int          ready_hold;
    t_ready_mode ready_mode;
    logic [BYTE_W-1:0] stream[$];

    nal_unit_extractor_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    nal_unit_extractor_core_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_ch          (in_ch),
        .i_out_ch         (out_ch),
        .o_mismatch_count (mismatches),
        .o_pending        (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (ready_hold == 0) begin
            ready_mode = t_ready_mode'($urandom_range(0, 2));
            ready_hold = $urandom_range(16, 64);
        end else begin
            ready_hold--;
        end
        case (ready_mode)
            RDY_ALWAYS: begin
                out_ch.ready <= 1'b1;
            end
            RDY_COIN: begin
                out_ch.ready <= ($urandom_range(0, 1) == 1);
            end
            default: begin
                out_ch.ready <= ($urandom_range(0, 5) == 0);
            end
        endcase
    end

    function automatic void add_byte(input logic [BYTE_W-1:0] b);
        stream = {stream, b};
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_ch.valid       <= 1'b1;
        in_ch.in_byte     <= b;
        in_ch.buffer_last <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_stream();
        for (int i = 0; i < stream.size(); i++) begin
            send_byte(stream[i], i == stream.size() - 1);
        end
        stream.delete();
    endtask

    function automatic logic [BYTE_W-1:0] payload_byte();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            return ZERO_BYTE;
        end else if (pick < 45) begin
            return ESC_BYTE;
        end else if (pick < 52) begin
            return START_BYTE;
        end
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    task automatic build_random_buffer();
        int units;
        int len;
        int term;
        if ($urandom_range(0, 4) == 0) begin
            len = $urandom_range(1, 10);
            repeat (len) add_byte(payload_byte());
        end else begin
            units = $urandom_range(1, 3);
            repeat (units) begin
                repeat ($urandom_range(0, 2)) add_byte(ZERO_BYTE);
                add_byte(ZERO_BYTE);
                add_byte(ZERO_BYTE);
                add_byte(START_BYTE);
                if ($urandom_range(0, 7) != 0) begin
                    add_byte(BYTE_W'($urandom_range(0, 255)));
                end
                len = $urandom_range(0, 8);
                repeat (len) begin
                    if ($urandom_range(0, 5) == 0) begin
                        add_byte(ZERO_BYTE);
                        add_byte(ZERO_BYTE);
                        add_byte(ESC_BYTE);
                    end else begin
                        add_byte(payload_byte());
                    end
                end
                term = $urandom_range(0, 2);
                if (term == 1) begin
                    repeat (3) add_byte(ZERO_BYTE);
                end else if (term == 2) begin
                    repeat ($urandom_range(1, 2)) add_byte(ZERO_BYTE);
                end
            end
        end
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.in_byte     <= '0;
        in_ch.buffer_last <= 1'b0;
        items_sent        = 0;
        burst_left        = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Header and payload, an escape after two zeros, a plain 03 after one
        // zero, a 00 00 00 terminator, an empty unit, a 00 00 01 terminator
        // and a held zero flushed at the buffer end.
        stream = '{8'h00, 8'h00, 8'h01, 8'h65, 8'hFF, 8'h00, 8'h00, 8'h03, 8'h00, 8'h03,
                   8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h80, 8'h00, 8'h00,
                   8'h01, 8'hAA, 8'h00};
        send_stream();
        stream = '{8'h00, 8'h00, 8'h01};
        send_stream();
        stream = '{8'h7F};
        send_stream();

        while (items_sent < RANDOM_ITEMS) begin
            build_random_buffer();
            send_stream();
        end

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
